@@ sv/blpw_pkg.sv @@
// Shared types and constants of the Bresenham line pixel writer.
`default_nettype none

package blpw_pkg;

   localparam int OFFSET_W = 24;
   localparam int COLOR_W  = 16;
   localparam int RES_W    = 12;
   localparam int STRIDE_W = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [RES_W-1:0]    X_RES_RESET  = 12'd640;
   localparam logic [RES_W-1:0]    Y_RES_RESET  = 12'd480;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd1280;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_RES  = 2'd0,
      CSR_Y_RES  = 2'd1,
      CSR_STRIDE = 2'd2
   } blpw_csr_type;

   typedef enum logic {
      ACT_START   = 1'b0,
      ACT_ADVANCE = 1'b1
   } blpw_action_type;

   // per-item control that travels with the pixel coordinates
   typedef struct packed {
      logic vld;     // stage holds an item
      logic rvalid;  // result carries a pixel
      logic last;    // pixel is the line's end point
   } blpw_ctl_type;

endpackage

`default_nettype wire

@@ sv/blpw_if.sv @@
// Handshake channel interfaces: draw requests, pixel results, register writes.
`default_nettype none

interface blpw_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;
   logic [15:0]           line_color;

   modport source (output valid, action, x_start, y_start, x_end, y_end, line_color,
                   input ready);
   modport sink   (input valid, action, x_start, y_start, x_end, y_end, line_color,
                   output ready);
endinterface

interface blpw_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_offset;
   logic [15:0] pixel_color;
   logic        write_enable;
   logic        last_pixel;
   logic        result_valid;

   modport source (output valid, pixel_offset, pixel_color, write_enable, last_pixel,
                   result_valid, input ready);
   modport sink   (input valid, pixel_offset, pixel_color, write_enable, last_pixel,
                   result_valid, output ready);
endinterface

interface blpw_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [13:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/blpw_stepper.sv @@
// Bresenham line state and step logic; its registers form the first pipe stage.
`default_nettype none

module blpw_stepper
   import blpw_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         stage_move,
   input  wire                         item_valid,
   input  wire                         action,
   input  wire  [COORD_BITS-1:0]       x_start,
   input  wire  [COORD_BITS-1:0]       y_start,
   input  wire  [COORD_BITS-1:0]       x_end,
   input  wire  [COORD_BITS-1:0]       y_end,
   input  wire  [COLOR_W-1:0]          line_color,
   output logic [COORD_BITS-1:0]       cur_x,
   output logic [COORD_BITS-1:0]       cur_y,
   output logic [COLOR_W-1:0]          cur_color,
   output blpw_ctl_type                ctl
);

   localparam int C  = COORD_BITS;
   localparam int EW = COORD_BITS + 2;   // error term stays within +-1.5 * 2^C

   logic [C-1:0]         cx_ff, cx_in, cy_ff, cy_in, tx_ff, tx_in, ty_ff, ty_in;
   logic [C-1:0]         adx_ff, adx_in;
   logic signed [C:0]    nady_ff, nady_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic [1:0]           dirs_ff, dirs_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic                 active_ff, active_in;
   blpw_ctl_type         ctl_ff, ctl_in;

   logic                 accept, start, load;
   logic signed [C:0]    dx, dy, adx_w, ady_w, nady_w;
   logic signed [EW:0]   e2, nady_e2, adx_e2;
   logic signed [EW-1:0] nady_e, adx_e, err_start, err_adv;
   logic                 step_x, step_y, last;
   logic [C-1:0]         x_adv, y_adv;

   assign accept = stage_move && item_valid;
   assign start  = (action == ACT_START);
   assign load   = accept && (start || active_ff);

   always_comb begin
      dx     = {x_end[C-1], x_end} - {x_start[C-1], x_start};
      dy     = {y_end[C-1], y_end} - {y_start[C-1], y_start};
      adx_w  = dx[C] ? -dx : dx;
      ady_w  = dy[C] ? -dy : dy;
      nady_w = -ady_w;

      nady_e  = {{(EW-C-1){nady_ff[C]}}, nady_ff};
      adx_e   = {{(EW-C){1'b0}}, adx_ff};
      e2      = {err_ff, 1'b0};
      nady_e2 = {nady_e[EW-1], nady_e};
      adx_e2  = {1'b0, adx_e};
      step_x  = (e2 >= nady_e2);
      step_y  = (e2 <= adx_e2);
      err_adv = err_ff + (step_x ? nady_e : '0) + (step_y ? adx_e : '0);
      x_adv   = cx_ff + (step_x ? (dirs_ff[0] ? {C{1'b1}} : C'(1)) : '0);
      y_adv   = cy_ff + (step_y ? (dirs_ff[1] ? {C{1'b1}} : C'(1)) : '0);

      // -|dy| is sign-extended to the error term width
      err_start = {{(EW-C){1'b0}}, adx_w[C-1:0]} +
                  {{(EW-C-1){nady_w[C]}}, nady_w};

      if (start) begin
         cx_in    = x_start;
         cy_in    = y_start;
         tx_in    = x_end;
         ty_in    = y_end;
         adx_in   = adx_w[C-1:0];
         nady_in  = nady_w;
         dirs_in  = {!(dy > 0), !(dx > 0)};
         err_in   = err_start;
         color_in = line_color;
      end else begin
         cx_in    = x_adv;
         cy_in    = y_adv;
         tx_in    = tx_ff;
         ty_in    = ty_ff;
         adx_in   = adx_ff;
         nady_in  = nady_ff;
         dirs_in  = dirs_ff;
         err_in   = err_adv;
         color_in = color_ff;
      end

      last      = (cx_in == tx_in) && (cy_in == ty_in);
      active_in = !last;

      ctl_in.vld    = item_valid;
      ctl_in.rvalid = item_valid && (start || active_ff);
      ctl_in.last   = item_valid && (start || active_ff) && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ctl_ff    <= '0;
      end else begin
         if (load) begin
            active_ff <= active_in;
         end
         if (stage_move) begin
            ctl_ff <= ctl_in;
         end
      end
      if (load) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         adx_ff   <= adx_in;
         nady_ff  <= nady_in;
         dirs_ff  <= dirs_in;
         err_ff   <= err_in;
         color_ff <= color_in;
      end
   end

   assign cur_x     = cx_ff;
   assign cur_y     = cy_ff;
   assign cur_color = color_ff;
   assign ctl       = ctl_ff;

endmodule

`default_nettype wire

@@ sv/bresenham_line_pixel_writer.sv @@
// Top level of the Bresenham line pixel writer: registers, pixel address stage, handshakes.
`default_nettype none

// Line rasterizer for a framebuffer. A start item (action 0) loads both
// endpoints and the colour and returns the first pixel; each advance item
// (action 1) returns the next pixel of the line, and an advance with no line
// active returns result_valid 0 with all other fields 0. Every item gives
// exactly one result. The block takes one item per cycle unless an untaken
// result holds rsp; results pass the stepper and output registers. The first
// stage is the Bresenham step update (two compares and up to two adds on the
// error term), the second computes the byte offset x*BYTES_PER_PIXEL +
// y*row_stride_bytes with one variable multiplier and the clipping against
// the visible resolution. Clipped pixels carry write_enable 0 and offset 0.
// The user must write registers through the csr channel only while the block
// is idle; the block does not enforce it. Unknown-index writes are ignored.
module bresenham_line_pixel_writer
   import blpw_pkg::*;
#(
   parameter int COORD_BITS      = 12,
   parameter int BYTES_PER_PIXEL = 2
) (
   input  wire      clock,
   input  wire      reset,
   blpw_req_if.sink req_ch,
   blpw_rsp_if.source rsp_ch,
   blpw_csr_if.sink csr_ch
);

   localparam int C   = COORD_BITS;
   localparam int CW  = (C > RES_W) ? C : RES_W;
   localparam int PYW = C + STRIDE_W;
   localparam int PXW = C + 3;
   localparam int SW  = ((PYW + 1) > OFFSET_W) ? (PYW + 1) : OFFSET_W;

   logic [RES_W-1:0]    xres_ff, yres_ff;
   logic [STRIDE_W-1:0] stride_ff;

   logic                out_vld_ff;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                we_ff, we_in, last_ff, last_in, rvalid_ff, rvalid_in;

   logic                out_move, stage_move;
   logic [C-1:0]        cur_x, cur_y;
   logic [COLOR_W-1:0]  cur_color;
   blpw_ctl_type        ctl;

   logic                vis;
   logic [PYW-1:0]      prod_y;
   logic [PXW-1:0]      prod_x;
   logic [SW-1:0]       sum;

   assign out_move   = !out_vld_ff || rsp_ch.ready;
   assign stage_move = !ctl.vld || out_move;
   assign req_ch.ready = stage_move;
   assign csr_ch.ready = 1'b1;

   blpw_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .stage_move (stage_move),
      .item_valid (req_ch.valid),
      .action     (req_ch.action),
      .x_start    (req_ch.x_start),
      .y_start    (req_ch.y_start),
      .x_end      (req_ch.x_end),
      .y_end      (req_ch.y_end),
      .line_color (req_ch.line_color),
      .cur_x      (cur_x),
      .cur_y      (cur_y),
      .cur_color  (cur_color),
      .ctl        (ctl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         xres_ff   <= X_RES_RESET;
         yres_ff   <= Y_RES_RESET;
         stride_ff <= STRIDE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_X_RES:  xres_ff   <= csr_ch.data[RES_W-1:0];
            CSR_Y_RES:  yres_ff   <= csr_ch.data[RES_W-1:0];
            CSR_STRIDE: stride_ff <= csr_ch.data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      vis = ctl.rvalid && !cur_x[C-1] && !cur_y[C-1] &&
            (CW'(cur_x) < CW'(xres_ff)) && (CW'(cur_y) < CW'(yres_ff));
      prod_y = PYW'(cur_y) * PYW'(stride_ff);
      prod_x = PXW'(cur_x) * PXW'(BYTES_PER_PIXEL);
      sum    = SW'(prod_y) + SW'(prod_x);

      offset_in = vis ? sum[OFFSET_W-1:0] : '0;
      color_in  = ctl.rvalid ? cur_color : '0;
      we_in     = vis;
      last_in   = ctl.last;
      rvalid_in = ctl.rvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_move) begin
         out_vld_ff <= ctl.vld;
      end
      if (out_move) begin
         offset_ff <= offset_in;
         color_ff  <= color_in;
         we_ff     <= we_in;
         last_ff   <= last_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.pixel_offset = offset_ff;
   assign rsp_ch.pixel_color  = color_ff;
   assign rsp_ch.write_enable = we_ff;
   assign rsp_ch.last_pixel   = last_ff;
   assign rsp_ch.result_valid = rvalid_ff;

endmodule

`default_nettype wire
